>>> src/assert_macros.svh
// assertion macros used by the checker file rtcrd_checker.sv
// depends on a clock named clk and a reset named arst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define RTCRD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define RTCRD_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

>>> src/rtcrd_pkg.sv
// types, constants and helper functions for the rtc register decoder
// no dependencies
package rtcrd_pkg;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_OSC_STOPPED = 3'd1,
		ST_CLK_STOPPED = 3'd2,
		ST_EXT_TEST    = 3'd3,
		ST_TWELVE_HOUR = 3'd4,
		ST_BAD_TIME    = 3'd5
	} status_t;

	localparam logic [11:0] MIN_YEAR_RESET = 12'd2001;
	localparam logic [11:0] YEAR_BASE      = 12'd2000;
	localparam logic [11:0] YEAR_LAST      = 12'd2099;

	localparam int CTRL_EXT_TEST_BIT = 7;
	localparam int CTRL_STOP_BIT     = 5;
	localparam int CTRL_12H_BIT      = 1;
	localparam int SEC_OSC_STOP_BIT  = 7;

	// packed bcd byte to binary, 0..165
	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] tens8;
		logic [7:0] tens2;
		tens8 = {1'b0, b[7:4], 3'b000};
		tens2 = {3'b000, b[7:4], 1'b0};
		return tens8 + tens2 + {4'b0000, b[3:0]};
	endfunction

	function automatic logic nibbles_ok(input logic [7:0] b);
		return (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
	endfunction

	// days in a non-leap month, month 1..12
	function automatic logic [4:0] month_length(input logic [3:0] month);
		logic [4:0] len;
		case (month)
			4'd2: len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

>>> src/rtc_register_decode.sv
// rtc register decoder: status, seconds of day and calendar date from one snapshot
// depends on rtcrd_pkg
// the result word is registered twice: first in the input register, then in the result register
// throughput: one word per cycle while out_ready is high; the input register refills while a result is being taken
// reset: arst_n clears both valid flags and sets min_year to 2001
// payload registers are not reset
module rtc_register_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  control_byte,
	input  logic [7:0]  seconds_reg,
	input  logic [7:0]  minutes_reg,
	input  logic [7:0]  hours_reg,
	input  logic [7:0]  days_reg,
	input  logic [7:0]  weekdays_reg,
	input  logic [7:0]  months_reg,
	input  logic [7:0]  years_reg,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [16:0] seconds_of_day,
	output logic [5:0]  day_of_month,
	output logic [2:0]  weekday,
	output logic [4:0]  month_number,
	output logic [11:0] year_number,
	output logic        date_valid
);

	logic [11:0] min_year_q;

	logic        valid_s1;
	logic [7:0]  ctrl_s1, sec_s1, min_s1, hour_s1, day_s1, wday_s1, mon_s1, year_s1;

	logic        valid_s2;
	logic [2:0]  status_s2;
	logic [16:0] secs_s2;
	logic [5:0]  day_s2;
	logic [2:0]  wday_s2;
	logic [4:0]  mon_s2;
	logic [11:0] year_s2;
	logic        dvalid_s2;

	logic        adv_s1;

	rtcrd_pkg::status_t st;
	logic [7:0]  s_b, m_b, h_b, d_b, mo_b, y_b;
	logic [7:0]  s_bin, m_bin, h_bin, d_bin, mo_bin, y_bin;
	logic [16:0] secs;
	logic [11:0] year;
	logic [4:0]  last_day;
	logic        time_ok, digits_ok, range_ok, date_ok;
	logic [2:0]  wd;

	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= rtcrd_pkg::MIN_YEAR_RESET;
		end else if (cfg_we) begin
			min_year_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_s1 <= control_byte;
			sec_s1  <= seconds_reg;
			min_s1  <= minutes_reg;
			hour_s1 <= hours_reg;
			day_s1  <= days_reg;
			wday_s1 <= weekdays_reg;
			mon_s1  <= months_reg;
			year_s1 <= years_reg;
		end
	end

	// decode
	always_comb begin
		s_b  = {1'b0, sec_s1[6:0]};
		m_b  = {1'b0, min_s1[6:0]};
		h_b  = {2'b00, hour_s1[5:0]};
		d_b  = {2'b00, day_s1[5:0]};
		mo_b = {3'b000, mon_s1[4:0]};
		y_b  = year_s1;
		wd   = wday_s1[2:0];

		s_bin  = rtcrd_pkg::bcd_value(s_b);
		m_bin  = rtcrd_pkg::bcd_value(m_b);
		h_bin  = rtcrd_pkg::bcd_value(h_b);
		d_bin  = rtcrd_pkg::bcd_value(d_b);
		mo_bin = rtcrd_pkg::bcd_value(mo_b);
		y_bin  = rtcrd_pkg::bcd_value(y_b);

		time_ok = rtcrd_pkg::nibbles_ok(s_b) && rtcrd_pkg::nibbles_ok(m_b)
			&& rtcrd_pkg::nibbles_ok(h_b)
			&& (s_bin <= 8'd59) && (m_bin <= 8'd59) && (h_bin <= 8'd23);

		if (sec_s1[rtcrd_pkg::SEC_OSC_STOP_BIT]) begin
			st = rtcrd_pkg::ST_OSC_STOPPED;
		end else if (ctrl_s1[rtcrd_pkg::CTRL_STOP_BIT]) begin
			st = rtcrd_pkg::ST_CLK_STOPPED;
		end else if (ctrl_s1[rtcrd_pkg::CTRL_EXT_TEST_BIT]) begin
			st = rtcrd_pkg::ST_EXT_TEST;
		end else if (ctrl_s1[rtcrd_pkg::CTRL_12H_BIT]) begin
			st = rtcrd_pkg::ST_TWELVE_HOUR;
		end else if (!time_ok) begin
			st = rtcrd_pkg::ST_BAD_TIME;
		end else begin
			st = rtcrd_pkg::ST_OK;
		end

		secs = 17'(h_bin) * 17'd3600 + 17'(m_bin) * 17'd60 + 17'(s_bin);
		year = rtcrd_pkg::YEAR_BASE + 12'(y_bin);

		last_day = rtcrd_pkg::month_length(mo_bin[3:0])
			+ 5'((mo_bin == 8'd2) && (y_bin[1:0] == 2'b00));

		digits_ok = rtcrd_pkg::nibbles_ok(d_b) && rtcrd_pkg::nibbles_ok(mo_b)
			&& rtcrd_pkg::nibbles_ok(y_b) && (wd <= 3'd6);
		range_ok  = (mo_bin >= 8'd1) && (mo_bin <= 8'd12) && (d_bin >= 8'd1)
			&& (d_bin <= 8'd31) && (year >= min_year_q)
			&& (year <= rtcrd_pkg::YEAR_LAST);
		date_ok   = digits_ok && range_ok && (d_bin <= {3'b000, last_day});
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_s2 <= st;
			if (st == rtcrd_pkg::ST_OK) begin
				secs_s2   <= secs;
				day_s2    <= d_bin[5:0];
				wday_s2   <= (wd == 3'd0) ? 3'd7 : wd;
				mon_s2    <= mo_bin[4:0];
				year_s2   <= date_ok ? year : 12'd0;
				dvalid_s2 <= date_ok;
			end else begin
				secs_s2   <= '0;
				day_s2    <= '0;
				wday_s2   <= '0;
				mon_s2    <= '0;
				year_s2   <= '0;
				dvalid_s2 <= 1'b0;
			end
		end
	end

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign seconds_of_day = secs_s2;
	assign day_of_month   = day_s2;
	assign weekday        = wday_s2;
	assign month_number   = mon_s2;
	assign year_number    = year_s2;
	assign date_valid     = dvalid_s2;

endmodule

>>> src/rtcrd_checker.sv
// port-level checks for the rtc register decoder, bound into rtc_register_decode
// depends on rtcrd_pkg and assert_macros.svh
`include "assert_macros.svh"

module rtcrd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [16:0] seconds_of_day,
	input logic [11:0] year_number,
	input logic        date_valid
);

	`RTCRD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(year_number), "result word changed while stalled")
	`RTCRD_ASSERT(a_fault_zero, out_valid && status != rtcrd_pkg::ST_OK |-> seconds_of_day == 17'd0 && year_number == 12'd0 && !date_valid, "fault status with nonzero fields")
	`RTCRD_ASSERT(a_date_year, out_valid && date_valid |-> status == rtcrd_pkg::ST_OK && year_number >= rtcrd_pkg::YEAR_BASE && year_number <= rtcrd_pkg::YEAR_LAST, "valid date with bad year")
	`RTCRD_ASSERT(a_nodate_year, out_valid && !date_valid |-> year_number == 12'd0, "invalid date with nonzero year")
	`RTCRD_ASSERT_NEVER(a_secs_range, out_valid && seconds_of_day > 17'd86399, "seconds of day out of range")

endmodule

bind rtc_register_decode rtcrd_checker u_rtcrd_checker (.*);

>>> tb/rtc_register_decode_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for rtc_register_decode: directed and random register snapshots
// with random valid/ready gaps, a receiver hold-off and min_year sweeps
// depends on rtcrd_pkg and rtc_register_decode
module rtc_register_decode_tb;

	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [7:0] control;
		logic [7:0] seconds;
		logic [7:0] minutes;
		logic [7:0] hours;
		logic [7:0] days;
		logic [7:0] weekdays;
		logic [7:0] months;
		logic [7:0] years;
	} snapshot_t;

	typedef struct {
		rtcrd_pkg::status_t status;
		logic [16:0] seconds_of_day;
		logic [5:0]  day_of_month;
		logic [2:0]  weekday;
		logic [4:0]  month_number;
		logic [11:0] year_number;
		logic        date_valid;
	} rtc_reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [11:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  control_byte;
	logic [7:0]  seconds_reg;
	logic [7:0]  minutes_reg;
	logic [7:0]  hours_reg;
	logic [7:0]  days_reg;
	logic [7:0]  weekdays_reg;
	logic [7:0]  months_reg;
	logic [7:0]  years_reg;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [16:0] seconds_of_day;
	logic [5:0]  day_of_month;
	logic [2:0]  weekday;
	logic [4:0]  month_number;
	logic [11:0] year_number;
	logic        date_valid;

	rtc_reading_t pending_readings[$];
	logic [11:0]  floor_year;
	int           mismatch_count = 0;
	logic         no_gaps;
	logic         hold_request;

	rtc_register_decode dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.control_byte   (control_byte),
		.seconds_reg    (seconds_reg),
		.minutes_reg    (minutes_reg),
		.hours_reg      (hours_reg),
		.days_reg       (days_reg),
		.weekdays_reg   (weekdays_reg),
		.months_reg     (months_reg),
		.years_reg      (years_reg),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.seconds_of_day (seconds_of_day),
		.day_of_month   (day_of_month),
		.weekday        (weekday),
		.month_number   (month_number),
		.year_number    (year_number),
		.date_valid     (date_valid)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned bcd_to_int(input logic [7:0] b);
		return int'(b[7:4]) * 10 + int'(b[3:0]);
	endfunction

	function automatic logic bcd_ok(input logic [7:0] b);
		return (b[7:4] < 4'd10) && (b[3:0] < 4'd10);
	endfunction

	function automatic logic [7:0] to_bcd(input int unsigned v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	function automatic rtc_reading_t decode_snapshot(input snapshot_t snap,
		input logic [11:0] lowest_year);
		rtc_reading_t r;
		logic [7:0] sec_b, min_b, hr_b, day_b, mon_b;
		int unsigned day, mon, yr, last;
		logic cal_ok;
		r.status = rtcrd_pkg::ST_OK;
		r.seconds_of_day = '0;
		r.day_of_month = '0;
		r.weekday = '0;
		r.month_number = '0;
		r.year_number = '0;
		r.date_valid = 1'b0;
		sec_b = {1'b0, snap.seconds[6:0]};
		min_b = {1'b0, snap.minutes[6:0]};
		hr_b = {2'b00, snap.hours[5:0]};
		if (snap.seconds[rtcrd_pkg::SEC_OSC_STOP_BIT])
			r.status = rtcrd_pkg::ST_OSC_STOPPED;
		else if (snap.control[rtcrd_pkg::CTRL_STOP_BIT])
			r.status = rtcrd_pkg::ST_CLK_STOPPED;
		else if (snap.control[rtcrd_pkg::CTRL_EXT_TEST_BIT])
			r.status = rtcrd_pkg::ST_EXT_TEST;
		else if (snap.control[rtcrd_pkg::CTRL_12H_BIT])
			r.status = rtcrd_pkg::ST_TWELVE_HOUR;
		else if (!bcd_ok(sec_b) || !bcd_ok(min_b) || !bcd_ok(hr_b)
			|| bcd_to_int(sec_b) > 59 || bcd_to_int(min_b) > 59
			|| bcd_to_int(hr_b) > 23)
			r.status = rtcrd_pkg::ST_BAD_TIME;
		if (r.status != rtcrd_pkg::ST_OK)
			return r;
		day_b = {2'b00, snap.days[5:0]};
		mon_b = {3'b000, snap.months[4:0]};
		day = bcd_to_int(day_b);
		mon = bcd_to_int(mon_b);
		yr = int'(rtcrd_pkg::YEAR_BASE) + bcd_to_int(snap.years);
		cal_ok = bcd_ok(day_b) && bcd_ok(mon_b) && bcd_ok(snap.years)
			&& snap.weekdays[2:0] != 3'd7;
		if (cal_ok)
			cal_ok = mon >= 1 && mon <= 12 && day >= 1 && day <= 31
				&& yr >= int'(lowest_year) && yr <= int'(rtcrd_pkg::YEAR_LAST);
		if (cal_ok) begin
			case (mon)
				2: last = (yr % 4 == 0) ? 29 : 28;
				4, 6, 9, 11: last = 30;
				default: last = 31;
			endcase
			cal_ok = day <= last;
		end
		r.seconds_of_day = 17'(bcd_to_int(hr_b) * 3600 + bcd_to_int(min_b) * 60
			+ bcd_to_int(sec_b));
		r.day_of_month = 6'(day);
		r.weekday = (snap.weekdays[2:0] == 3'd0) ? 3'd7 : snap.weekdays[2:0];
		r.month_number = 5'(mon);
		r.year_number = cal_ok ? 12'(yr) : 12'd0;
		r.date_valid = cal_ok;
		return r;
	endfunction

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int unsigned roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// well-formed snapshots with random content, some broken, some pure noise
	function automatic snapshot_t random_snapshot();
		snapshot_t snap;
		int unsigned roll;
		int unsigned k;
		roll = $urandom_range(0, 99);
		if (roll >= 88)
			return snapshot_t'({$urandom, $urandom});
		snap.control = 8'($urandom) & ~8'hA2;
		snap.seconds = to_bcd($urandom_range(0, 59));
		snap.minutes = to_bcd($urandom_range(0, 59));
		snap.minutes[7] = 1'($urandom);
		snap.hours = to_bcd($urandom_range(0, 23));
		snap.hours[7:6] = 2'($urandom);
		snap.days = to_bcd(($urandom_range(0, 3) == 0) ? $urandom_range(28, 31)
			: $urandom_range(1, 28));
		snap.days[7:6] = 2'($urandom);
		snap.weekdays = {5'($urandom), 3'($urandom_range(0, 6))};
		snap.months = to_bcd($urandom_range(1, 12));
		snap.months[7:5] = 3'($urandom);
		snap.years = to_bcd($urandom_range(0, 99));
		if (roll >= 80) begin
			case ($urandom_range(0, 3))
				0: snap.seconds[rtcrd_pkg::SEC_OSC_STOP_BIT] = 1'b1;
				1: snap.control[rtcrd_pkg::CTRL_STOP_BIT] = 1'b1;
				2: snap.control[rtcrd_pkg::CTRL_EXT_TEST_BIT] = 1'b1;
				default: snap.control[rtcrd_pkg::CTRL_12H_BIT] = 1'b1;
			endcase
		end else if (roll >= 65) begin
			k = $urandom_range(0, 7);
			snap[k * 8 +: 8] = 8'($urandom);
		end
		return snap;
	endfunction

	task automatic send_word(input snapshot_t snap);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		control_byte <= snap.control;
		seconds_reg <= snap.seconds;
		minutes_reg <= snap.minutes;
		hours_reg <= snap.hours;
		days_reg <= snap.days;
		weekdays_reg <= snap.weekdays;
		months_reg <= snap.months;
		years_reg <= snap.years;
		do @(posedge clk); while (!in_ready);
		pending_readings.push_back(decode_snapshot(snap, floor_year));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drop valid and wait for every outstanding word
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_year_floor(input logic [11:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		floor_year = value;
	endtask

	task automatic test_status_priority();
		send_word({8'hA2, 8'h80, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'hA2, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h82, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h00, 8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h00, 8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h00, 8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h00, 8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h01, 8'h01});
		send_word({8'h00, 8'h00, 8'h00, 8'h1A, 8'h01, 8'h01, 8'h01, 8'h01});
		drain_pipeline();
	endtask

	task automatic test_calendar_limits();
		send_word({8'h00, 8'h59, 8'h59, 8'h23, 8'h31, 8'h06, 8'h12, 8'h99});
		send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h01});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h03, 8'h06, 8'h00});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h29, 8'h04, 8'h02, 8'h24});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h29, 8'h04, 8'h02, 8'h23});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h28, 8'h04, 8'h02, 8'h23});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h31, 8'h04, 8'h04, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h30, 8'h04, 8'h04, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h07, 8'h06, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h01, 8'h00, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h01, 8'h13, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h00, 8'h01, 8'h06, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h3F, 8'h01, 8'h06, 8'h30});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h01, 8'h06, 8'h9A});
		send_word({8'h00, 8'h56, 8'h34, 8'h12, 8'h15, 8'h01, 8'h1F, 8'h30});
		// every ignored bit set around a valid date
		send_word({8'h5D, 8'h59, 8'hD9, 8'hE3, 8'hF1, 8'hFE, 8'hF2, 8'h99});
		drain_pipeline();
	endtask

	task automatic test_year_floor();
		logic [11:0] floors [6];
		floors[0] = 12'd2000;
		floors[1] = rtcrd_pkg::YEAR_LAST;
		floors[2] = 12'hFFF;
		floors[3] = 12'd0;
		floors[4] = 12'd2100;
		floors[5] = 12'($urandom_range(2000, 2099));
		for (int i = 0; i < 6; i++) begin
			set_year_floor(floors[i]);
			send_word({8'h00, 8'h30, 8'h15, 8'h12, 8'h29, 8'h02, 8'h02, 8'h00});
			send_word({8'h00, 8'h30, 8'h15, 8'h12, 8'h31, 8'h05, 8'h12, 8'h99});
			repeat (25) send_word(random_snapshot());
			drain_pipeline();
		end
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_request = 1'b1;
		repeat (24) send_word(random_snapshot());
		no_gaps = 1'b0;
		drain_pipeline();
	endtask

	task automatic test_random_traffic();
		for (int chunk = 0; chunk < 4; chunk++) begin
			if (chunk == 0)
				set_year_floor(rtcrd_pkg::MIN_YEAR_RESET);
			else if (chunk == 2)
				set_year_floor(12'($urandom_range(2000, 2099)));
			no_gaps = (chunk == 1);
			repeat (110) send_word(random_snapshot());
			no_gaps = 1'b0;
			drain_pipeline();
		end
	endtask

	// receiver side: random stalls plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic compare_field(input string field, input logic [16:0] want,
		input logic [16:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		rtc_reading_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word, expected none, actual status %0d", $time, status);
			end else begin
				want = pending_readings.pop_front();
				compare_field("status", 17'(want.status), 17'(status));
				compare_field("seconds_of_day", want.seconds_of_day, seconds_of_day);
				compare_field("day_of_month", 17'(want.day_of_month), 17'(day_of_month));
				compare_field("weekday", 17'(want.weekday), 17'(weekday));
				compare_field("month_number", 17'(want.month_number), 17'(month_number));
				compare_field("year_number", 17'(want.year_number), 17'(year_number));
				compare_field("date_valid", 17'(want.date_valid), 17'(date_valid));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		control_byte = '0;
		seconds_reg = '0;
		minutes_reg = '0;
		hours_reg = '0;
		days_reg = '0;
		weekdays_reg = '0;
		months_reg = '0;
		years_reg = '0;
		floor_year = rtcrd_pkg::MIN_YEAR_RESET;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_status_priority();
		test_calendar_limits();
		test_year_floor();
		test_backpressure();
		test_random_traffic();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
